// ===== src/tpsd_pkg.sv =====
// ============================================================================
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder.
// ============================================================================
package tpsd_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMPRESSED  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIXEL_BYTES = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIXEL_TOTAL = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_CLIPPED     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic [2:0] BYTES_555  = 3'd2;
    localparam logic [2:0] BYTES_BGR  = 3'd3;
    localparam logic [2:0] BYTES_BGRA = 3'd4;

    localparam logic [7:0] RUN_FLAG_MIN = 8'd128;
    localparam logic [7:0] RUN_BIAS     = 8'd127;

    typedef struct packed {
        logic       compressed;
        logic [2:0] nb;
        logic       restart;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       last_pixel;
        logic [1:0] status;
    } t_pixel;

endpackage

// ===== src/tga_pixel_stream_decoder_unit.sv =====
// ============================================================================
// tga_pixel_stream_decoder_unit
// TGA pixel data decoder: bytes in, RGBA pixel beats with repeat counts out.
// ============================================================================
//
//  Channel  Direction  Handshake                   Payload
//  -------  ---------  --------------------------  ------------------------------
//  in       sink       i_in_valid / o_in_stall     i_data_byte
//  out      source     o_out_valid / i_out_stall   o_red .. o_alpha, o_repeat_res,
//                                                  o_last_pixel, o_status
//  cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One byte is accepted every cycle unless the input stalls; a pixel beat is
// decoded from the input register and then held in the result register.
// The decode state is updated once per byte in a single combinational pass.
// Reset is synchronous and restores the register reset values.
// A stalled output holds the pipeline; the input stalls only while the
// result register is full and stalled.
//
module tga_pixel_stream_decoder_unit
    import tpsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic [7:0]                 o_alpha,
    output logic [7:0]                 o_repeat_res,
    output logic                       o_last_pixel,
    output logic [1:0]                 o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    t_cfg                   cfg;
    logic [COUNT_WIDTH-1:0] reload;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   advance;
    logic                   fire;
    logic                   in_accept;
    logic                   res_valid;
    t_pixel                 res;
    t_pixel                 out_res;

    assign o_cfg_ready = 1'b1;
    assign advance     = !o_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    tpsd_cfg #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_reload    (reload)
    );

    tpsd_decode #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_reload    (reload),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tpsd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_red        = out_res.red;
    assign o_green      = out_res.green;
    assign o_blue       = out_res.blue;
    assign o_alpha      = out_res.alpha;
    assign o_repeat_res = out_res.repeat_res;
    assign o_last_pixel = out_res.last_pixel;
    assign o_status     = out_res.status;

endmodule

// ===== src/tpsd_cfg.sv =====
// ============================================================================
// tpsd_cfg
// Configuration registers, effective pixel size and counter reload value.
// ============================================================================
module tpsd_cfg
    import tpsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output t_cfg                       o_cfg,
    output logic [COUNT_WIDTH-1:0]     o_reload
);

    logic                      r_compressed;
    logic [2:0]                r_pixel_bytes;
    logic [CFG_DATA_WIDTH-1:0] r_pixel_total;
    logic                      n_restart;
    logic [CFG_DATA_WIDTH-1:0] n_pixel_total;
    logic [COUNT_WIDTH-1:0]    n_masked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed  <= 1'b0;
            r_pixel_bytes <= BYTES_BGR;
            r_pixel_total <= CFG_DATA_WIDTH'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COMPRESSED:  r_compressed  <= i_cfg_data[0];
                REG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[2:0];
                REG_PIXEL_TOTAL: r_pixel_total <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_restart = 1'b0;
        case (i_cfg_index)
            REG_COMPRESSED, REG_PIXEL_BYTES, REG_PIXEL_TOTAL: n_restart = i_cfg_valid;
            default: n_restart = 1'b0;
        endcase
    end

    // A write of the pixel total restarts the image with the new count.
    always_comb begin
        if (i_cfg_valid && i_cfg_index == REG_PIXEL_TOTAL) begin
            n_pixel_total = i_cfg_data;
        end else begin
            n_pixel_total = r_pixel_total;
        end
    end

    assign n_masked = n_pixel_total[COUNT_WIDTH-1:0];
    assign o_reload = (n_masked == '0) ? COUNT_WIDTH'(1) : n_masked;

    always_comb begin
        o_cfg.compressed = r_compressed;
        o_cfg.restart    = n_restart;
        if (r_pixel_bytes < BYTES_555) begin
            o_cfg.nb = BYTES_555;
        end else if (r_pixel_bytes > BYTES_BGRA) begin
            o_cfg.nb = BYTES_BGRA;
        end else begin
            o_cfg.nb = r_pixel_bytes;
        end
    end

endmodule

// ===== src/tpsd_decode.sv =====
// ============================================================================
// tpsd_decode
// Packet and pixel state with the single-pass pixel decode of one byte.
// ============================================================================
module tpsd_decode
    import tpsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic [COUNT_WIDTH-1:0] i_reload,
    input  logic                   i_fire,
    input  logic [7:0]             i_byte,
    output logic                   o_res_valid,
    output t_pixel                 o_res
);

    logic                   r_expect_header;
    logic                   r_run_packet;
    logic [7:0]             r_packet_left;
    logic [1:0]             r_byte_index;
    logic [23:0]            r_held;
    logic [COUNT_WIDTH-1:0] r_pixels_left;

    logic                   n_expect_header;
    logic                   n_run_packet;
    logic [7:0]             n_packet_left;
    logic [1:0]             n_byte_index;
    logic [23:0]            n_held;
    logic [COUNT_WIDTH-1:0] n_pixels_left;
    logic [COUNT_WIDTH-1:0] n_after;
    logic [15:0]            n_word;
    logic [7:0]             n_dec;

    always_comb begin
        n_expect_header = r_expect_header;
        n_run_packet    = r_run_packet;
        n_packet_left   = r_packet_left;
        n_byte_index    = r_byte_index;
        n_held          = r_held;
        n_pixels_left   = r_pixels_left;
        n_after         = r_pixels_left;
        n_word          = {i_byte, r_held[7:0]};
        n_dec           = '0;
        o_res_valid     = 1'b0;
        o_res           = '0;
        o_res.repeat_res = 8'd1;
        o_res.status     = ST_OK;

        if (i_cfg.compressed && r_expect_header) begin
            n_run_packet    = i_byte[7];
            n_packet_left   = (i_byte >= RUN_FLAG_MIN) ? 8'(i_byte - RUN_BIAS)
                                                       : 8'(i_byte + 8'd1);
            n_expect_header = 1'b0;
            n_byte_index    = '0;
            n_held          = '0;
        end else if (({1'b0, r_byte_index} + 3'd1) < i_cfg.nb) begin
            case (r_byte_index)
                2'd0:    n_held = {r_held[23:8], r_held[7:0] | i_byte};
                2'd1:    n_held = {r_held[23:16], r_held[15:8] | i_byte, r_held[7:0]};
                2'd2:    n_held = {r_held[23:16] | i_byte, r_held[15:0]};
                default: n_held = r_held;
            endcase
            n_byte_index = 2'(r_byte_index + 2'd1);
        end else begin
            o_res_valid = 1'b1;
            case (i_cfg.nb)
                BYTES_555: begin
                    o_res.blue  = {n_word[4:0], 3'b000};
                    o_res.green = {n_word[9:5], 3'b000};
                    o_res.red   = {n_word[14:10], 3'b000};
                end
                BYTES_BGR: begin
                    o_res.blue  = r_held[7:0];
                    o_res.green = r_held[15:8];
                    o_res.red   = i_byte;
                end
                default: begin
                    o_res.blue  = r_held[7:0];
                    o_res.green = r_held[15:8];
                    o_res.red   = r_held[23:16];
                    o_res.alpha = i_byte;
                end
            endcase
            n_byte_index = '0;
            n_held       = '0;

            if (i_cfg.compressed) begin
                if (i_cfg.nb == BYTES_555) begin
                    o_res.red    = '0;
                    o_res.green  = '0;
                    o_res.blue   = '0;
                    o_res.alpha  = '0;
                    o_res.status = ST_UNSUPPORTED;
                end
                if (r_run_packet) begin
                    o_res.repeat_res = (r_packet_left == '0) ? 8'd1 : r_packet_left;
                    n_packet_left    = '0;
                    n_expect_header  = 1'b1;
                end else begin
                    n_dec = (r_packet_left == '0) ? 8'd0 : 8'(r_packet_left - 8'd1);
                    n_packet_left = n_dec;
                    if (n_dec == '0) begin
                        n_expect_header = 1'b1;
                    end
                end
            end

            if (COUNT_WIDTH'(o_res.repeat_res) > r_pixels_left) begin
                o_res.repeat_res = r_pixels_left[7:0];
                o_res.status     = ST_CLIPPED;
            end
            n_after       = r_pixels_left - COUNT_WIDTH'(o_res.repeat_res);
            n_pixels_left = n_after;
            if (n_after == '0) begin
                o_res.last_pixel = 1'b1;
                n_pixels_left    = i_reload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_run_packet    <= 1'b0;
            r_packet_left   <= '0;
            r_byte_index    <= '0;
            r_held          <= '0;
            r_pixels_left   <= COUNT_WIDTH'(1);
        end else if (i_cfg.restart) begin
            r_expect_header <= 1'b1;
            r_run_packet    <= 1'b0;
            r_packet_left   <= '0;
            r_byte_index    <= '0;
            r_held          <= '0;
            r_pixels_left   <= i_reload;
        end else if (i_fire) begin
            r_expect_header <= n_expect_header;
            r_run_packet    <= n_run_packet;
            r_packet_left   <= n_packet_left;
            r_byte_index    <= n_byte_index;
            r_held          <= n_held;
            r_pixels_left   <= n_pixels_left;
        end
    end

endmodule

// ===== src/tpsd_out_reg.sv =====
// ============================================================================
// tpsd_out_reg
// Result register that holds a decoded pixel beat until it is taken.
// ============================================================================
module tpsd_out_reg
    import tpsd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  logic   i_fire,
    input  logic   i_res_valid,
    input  t_pixel i_res,
    output logic   o_valid,
    output t_pixel o_res
);

    logic   r_valid;
    t_pixel r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_fire && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== src/tpsd_checker.sv =====
// ============================================================================
// tpsd_checker
// Port-level checks of the TGA pixel stream decoder, bound to the top level.
// ============================================================================
module tpsd_checker
    import tpsd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic [7:0] o_alpha,
    input logic [7:0] o_repeat_res,
    input logic       o_last_pixel,
    input logic [1:0] o_status
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output beat valid right after reset.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("Input stalled while the output could move.");

    a_repeat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_repeat_res != 8'd0 && o_repeat_res <= 8'd128))
        else $error("Repeat count out of range.");

    a_clip_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_CLIPPED) |-> o_last_pixel)
        else $error("Clipped run does not end the image.");

    a_unsup_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_UNSUPPORTED)
            |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'd0))
        else $error("Unsupported format beat carries a color.");

endmodule

bind tga_pixel_stream_decoder_unit tpsd_checker u_tpsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue),
    .o_alpha      (o_alpha),
    .o_repeat_res (o_repeat_res),
    .o_last_pixel (o_last_pixel),
    .o_status     (o_status)
);
